// ----- rtl/axdr_tve_pkg.sv -----
// Package for the A-XDR typed value encoder: command codes, type tags
// and length prefix constants. No dependencies.
`timescale 1ns / 1ps

package axdr_tve_pkg;

  typedef enum logic [4:0] {
    CMD_START      = 5'd0,
    CMD_NULL       = 5'd1,
    CMD_BOOL       = 5'd2,
    CMD_U8         = 5'd3,
    CMD_I8         = 5'd4,
    CMD_U16        = 5'd5,
    CMD_I16        = 5'd6,
    CMD_U32        = 5'd7,
    CMD_I32        = 5'd8,
    CMD_U64        = 5'd9,
    CMD_I64        = 5'd10,
    CMD_FLOAT      = 5'd11,
    CMD_ENUM       = 5'd12,
    CMD_OCTET_HDR  = 5'd13,
    CMD_VIS_HDR    = 5'd14,
    CMD_BITSTR_HDR = 5'd15,
    CMD_STRUCT_HDR = 5'd16,
    CMD_ARRAY_HDR  = 5'd17,
    CMD_RAW        = 5'd18,
    CMD_LENGTH     = 5'd19
  } cmd_t;

  localparam logic [7:0] TAG_NULL       = 8'd0;
  localparam logic [7:0] TAG_ARRAY      = 8'd1;
  localparam logic [7:0] TAG_STRUCT     = 8'd2;
  localparam logic [7:0] TAG_BOOL       = 8'd3;
  localparam logic [7:0] TAG_BITSTR     = 8'd4;
  localparam logic [7:0] TAG_I32        = 8'd5;
  localparam logic [7:0] TAG_U32        = 8'd6;
  localparam logic [7:0] TAG_OCTET      = 8'd9;
  localparam logic [7:0] TAG_VIS        = 8'd10;
  localparam logic [7:0] TAG_I8         = 8'd15;
  localparam logic [7:0] TAG_I16        = 8'd16;
  localparam logic [7:0] TAG_U8         = 8'd17;
  localparam logic [7:0] TAG_U16        = 8'd18;
  localparam logic [7:0] TAG_I64        = 8'd20;
  localparam logic [7:0] TAG_U64        = 8'd21;
  localparam logic [7:0] TAG_ENUM       = 8'd22;
  localparam logic [7:0] TAG_FLOAT      = 8'd23;

  localparam logic [7:0] LEN_PREFIX_1   = 8'h81;
  localparam logic [7:0] LEN_PREFIX_2   = 8'h82;
  localparam logic [7:0] LEN_PREFIX_4   = 8'h84;

  localparam logic [15:0] CAPACITY_RESET = 16'd1024;
  localparam logic [0:0]  REG_CAPACITY   = 1'b0;

endpackage

// ----- rtl/axdr_typed_value_encoder.sv -----
// Top level of the A-XDR typed value encoder: command decode, buffer
// offset tracking and byte serializer. Depends on axdr_tve_pkg.
`timescale 1ns / 1ps

// Usage:
// Each input beat carries a command in in_tuser and a 64-bit value in
// in_tdata. The block answers with a run of output beats, one byte each:
// a type tag and big-endian payload, or a tag and a BER-style length.
// out_tdata holds the byte and its buffer offset, out_tlast marks the
// final byte of an item and out_tuser flags an item that did not fit,
// which gives a single beat and writes nothing. Start and unused
// commands give no output beat; raw and length commands give no tag.
// The command is decoded in the cycle it is accepted and its bytes are
// loaded into the serializer, from which they move to the output register.
// An item has up to nine bytes, and the rate is one output byte per cycle
// while the receiver does not stall; the next item is taken in the cycle its
// predecessor's last byte moves to the output register.
// The capacity register is written through the APB port at address 0.
// Reset sets the capacity to 1024 and the offset to zero and empties the
// serializer. When the receiver stalls, the output register holds its
// beat and the serializer holds the remaining bytes.
module axdr_typed_value_encoder
  import axdr_tve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // value[63:0]
  input  logic [4:0]  in_tuser,   // command[4:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // data_byte[7:0], byte_position[23:8]
  output logic        out_tlast,
  output logic        out_tuser,  // overflow[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] capacity_r;
  logic [15:0] offset_r, offset_nxt;
  logic [71:0] buf_r, buf_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic        ovf_r, ovf_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [15:0] out_pos_r, out_pos_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_ovf_r, out_ovf_nxt;

  logic        out_free;
  logic        shift_en;
  logic        accept;

  logic        enc_emit;
  logic        enc_start;
  logic        enc_tag_en;
  logic [7:0]  enc_tag;
  logic [63:0] enc_pay;
  logic [3:0]  enc_pay_n;
  logic [3:0]  enc_n;
  logic [71:0] enc_bytes;
  logic [31:0] len;
  logic [39:0] len_vec;
  logic [3:0]  len_n;
  logic        fits;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? {16'd0, capacity_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_CAPACITY) begin
      capacity_r <= cfg_pwdata[15:0];
    end
  end

  assign len = in_tdata[31:0];

  always_comb begin
    if (len <= 32'h7F) begin
      len_vec = {len[7:0], 32'd0};
      len_n   = 4'd1;
    end else if (len <= 32'hFF) begin
      len_vec = {LEN_PREFIX_1, len[7:0], 24'd0};
      len_n   = 4'd2;
    end else if (len <= 32'hFFFF) begin
      len_vec = {LEN_PREFIX_2, len[15:0], 16'd0};
      len_n   = 4'd3;
    end else begin
      len_vec = {LEN_PREFIX_4, len};
      len_n   = 4'd5;
    end
  end

  always_comb begin
    enc_emit   = 1'b1;
    enc_start  = 1'b0;
    enc_tag_en = 1'b1;
    enc_tag    = TAG_NULL;
    enc_pay    = 64'd0;
    enc_pay_n  = 4'd0;
    case (cmd_t'(in_tuser))
      CMD_START: begin
        enc_emit  = 1'b0;
        enc_start = 1'b1;
      end
      CMD_NULL: begin
        enc_tag = TAG_NULL;
      end
      CMD_BOOL: begin
        enc_tag   = TAG_BOOL;
        enc_pay   = {7'd0, (in_tdata != 64'd0), 56'd0};
        enc_pay_n = 4'd1;
      end
      CMD_U8, CMD_I8, CMD_ENUM: begin
        priority if (in_tuser == CMD_U8) enc_tag = TAG_U8;
        else if (in_tuser == CMD_I8) enc_tag = TAG_I8;
        else enc_tag = TAG_ENUM;
        enc_pay   = {in_tdata[7:0], 56'd0};
        enc_pay_n = 4'd1;
      end
      CMD_U16, CMD_I16: begin
        enc_tag   = (in_tuser == CMD_U16) ? TAG_U16 : TAG_I16;
        enc_pay   = {in_tdata[15:0], 48'd0};
        enc_pay_n = 4'd2;
      end
      CMD_U32, CMD_I32, CMD_FLOAT: begin
        priority if (in_tuser == CMD_U32) enc_tag = TAG_U32;
        else if (in_tuser == CMD_I32) enc_tag = TAG_I32;
        else enc_tag = TAG_FLOAT;
        enc_pay   = {in_tdata[31:0], 32'd0};
        enc_pay_n = 4'd4;
      end
      CMD_U64, CMD_I64: begin
        enc_tag   = (in_tuser == CMD_U64) ? TAG_U64 : TAG_I64;
        enc_pay   = in_tdata;
        enc_pay_n = 4'd8;
      end
      CMD_OCTET_HDR, CMD_VIS_HDR, CMD_BITSTR_HDR, CMD_STRUCT_HDR, CMD_ARRAY_HDR: begin
        priority if (in_tuser == CMD_OCTET_HDR) enc_tag = TAG_OCTET;
        else if (in_tuser == CMD_VIS_HDR) enc_tag = TAG_VIS;
        else if (in_tuser == CMD_BITSTR_HDR) enc_tag = TAG_BITSTR;
        else if (in_tuser == CMD_STRUCT_HDR) enc_tag = TAG_STRUCT;
        else enc_tag = TAG_ARRAY;
        enc_pay   = {len_vec, 24'd0};
        enc_pay_n = len_n;
      end
      CMD_RAW: begin
        enc_tag_en = 1'b0;
        enc_pay    = {in_tdata[7:0], 56'd0};
        enc_pay_n  = 4'd1;
      end
      CMD_LENGTH: begin
        enc_tag_en = 1'b0;
        enc_pay    = {len_vec, 24'd0};
        enc_pay_n  = len_n;
      end
      default: begin
        enc_emit   = 1'b0;
        enc_tag_en = 1'b0;
      end
    endcase
  end

  assign enc_n     = enc_pay_n + {3'd0, enc_tag_en};
  assign enc_bytes = enc_tag_en ? {enc_tag, enc_pay} : {enc_pay, 8'd0};
  assign fits      = ({1'b0, offset_r} + {13'd0, enc_n}) <= {1'b0, capacity_r};

  assign out_free  = !out_valid_r || out_tready;
  assign shift_en  = out_free && (rem_r != 4'd0);
  assign in_tready = (rem_r == 4'd0) || (rem_r == 4'd1 && out_free);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    buf_nxt    = buf_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    ovf_nxt    = ovf_r;
    offset_nxt = offset_r;
    if (shift_en) begin
      buf_nxt = {buf_r[63:0], 8'd0};
      rem_nxt = rem_r - 4'd1;
      pos_nxt = pos_r + 16'd1;
    end
    if (accept) begin
      if (enc_start) begin
        offset_nxt = 16'd0;
      end else if (enc_emit) begin
        pos_nxt = offset_r;
        if (fits) begin
          buf_nxt    = enc_bytes;
          rem_nxt    = enc_n;
          ovf_nxt    = 1'b0;
          offset_nxt = offset_r + {12'd0, enc_n};
        end else begin
          buf_nxt = 72'd0;
          rem_nxt = 4'd1;
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_free) begin
      out_valid_nxt = shift_en;
      out_byte_nxt  = buf_r[71:64];
      out_pos_nxt   = pos_r;
      out_last_nxt  = (rem_r == 4'd1);
      out_ovf_nxt   = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= 16'd0;
      rem_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      offset_r    <= offset_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r      <= buf_nxt;
    pos_r      <= pos_nxt;
    ovf_r      <= ovf_nxt;
    out_byte_r <= out_byte_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for axdr_typed_value_encoder: predicts the tag,
// payload and length bytes of every accepted beat and checks each output beat.
// Depends on rtl/axdr_tve_pkg.sv and rtl/axdr_typed_value_encoder.sv.
`timescale 1ns / 1ps

module testbench;
  import axdr_tve_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] byte_position;
    logic        last_byte;
    logic        overflow;
  } axdr_beat_t;

  class axdr_byte_scoreboard;
    axdr_beat_t  expected_bytes[$];
    logic [15:0] capacity;
    logic [15:0] offset;
    int          mismatches;
    int          items_seen;
    int          beats_checked;
    int          overflow_beats;

    function new();
      capacity = CAPACITY_RESET;
      offset = '0;
    endfunction

    function void set_capacity(logic [15:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void flag_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void note_input(logic [4:0] cmd, logic [63:0] value);
      logic [7:0]  enc[$];
      logic [7:0]  tag;
      logic [31:0] len;
      bit          has_tag;
      bit          is_len;
      int          nbytes;
      axdr_beat_t  beat;
      items_seen++;
      has_tag = 1'b1;
      is_len = 1'b0;
      nbytes = 0;
      tag = TAG_NULL;
      len = value[31:0];
      if (cmd > CMD_LENGTH) return;
      case (cmd_t'(cmd))
        CMD_START: begin
          offset = '0;
          return;
        end
        CMD_NULL: tag = TAG_NULL;
        CMD_BOOL: begin
          tag = TAG_BOOL;
          nbytes = 1;
          value = (value != 64'd0) ? 64'd1 : 64'd0;
        end
        CMD_U8: begin
          tag = TAG_U8;
          nbytes = 1;
        end
        CMD_I8: begin
          tag = TAG_I8;
          nbytes = 1;
        end
        CMD_U16: begin
          tag = TAG_U16;
          nbytes = 2;
        end
        CMD_I16: begin
          tag = TAG_I16;
          nbytes = 2;
        end
        CMD_U32: begin
          tag = TAG_U32;
          nbytes = 4;
        end
        CMD_I32: begin
          tag = TAG_I32;
          nbytes = 4;
        end
        CMD_U64: begin
          tag = TAG_U64;
          nbytes = 8;
        end
        CMD_I64: begin
          tag = TAG_I64;
          nbytes = 8;
        end
        CMD_FLOAT: begin
          tag = TAG_FLOAT;
          nbytes = 4;
        end
        CMD_ENUM: begin
          tag = TAG_ENUM;
          nbytes = 1;
        end
        CMD_OCTET_HDR: begin
          tag = TAG_OCTET;
          is_len = 1'b1;
        end
        CMD_VIS_HDR: begin
          tag = TAG_VIS;
          is_len = 1'b1;
        end
        CMD_BITSTR_HDR: begin
          tag = TAG_BITSTR;
          is_len = 1'b1;
        end
        CMD_STRUCT_HDR: begin
          tag = TAG_STRUCT;
          is_len = 1'b1;
        end
        CMD_ARRAY_HDR: begin
          tag = TAG_ARRAY;
          is_len = 1'b1;
        end
        CMD_RAW: begin
          has_tag = 1'b0;
          nbytes = 1;
        end
        CMD_LENGTH: begin
          has_tag = 1'b0;
          is_len = 1'b1;
        end
        default: return;
      endcase
      if (has_tag) enc.push_back(tag);
      if (is_len) begin
        if (len <= 32'h7F) begin
          enc.push_back(len[7:0]);
        end else if (len <= 32'hFF) begin
          enc.push_back(LEN_PREFIX_1);
          nbytes = 1;
        end else if (len <= 32'hFFFF) begin
          enc.push_back(LEN_PREFIX_2);
          nbytes = 2;
        end else begin
          enc.push_back(LEN_PREFIX_4);
          nbytes = 4;
        end
      end
      for (int i = nbytes - 1; i >= 0; i--) enc.push_back(value[8*i +: 8]);
      if (int'(offset) + enc.size() > int'(capacity)) begin
        beat = '{data_byte: 8'h00, byte_position: offset, last_byte: 1'b1, overflow: 1'b1};
        expected_bytes.push_back(beat);
        return;
      end
      foreach (enc[i]) begin
        beat.data_byte = enc[i];
        beat.byte_position = offset + 16'(i);
        beat.last_byte = (i == enc.size() - 1);
        beat.overflow = 1'b0;
        expected_bytes.push_back(beat);
      end
      offset = offset + 16'(enc.size());
    endfunction

    function void check_byte(axdr_beat_t got);
      axdr_beat_t want;
      beats_checked++;
      if (got.overflow) overflow_beats++;
      if (expected_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat byte=%02h pos=%0d last=%0b ovf=%0b",
                                got.data_byte, got.byte_position, got.last_byte,
                                got.overflow));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data_byte !== want.data_byte || got.byte_position !== want.byte_position ||
          got.last_byte !== want.last_byte || got.overflow !== want.overflow)
        flag_mismatch($sformatf({"expected byte=%02h pos=%0d last=%0b ovf=%0b, ",
                                 "got byte=%02h pos=%0d last=%0b ovf=%0b"},
                                want.data_byte, want.byte_position, want.last_byte,
                                want.overflow, got.data_byte, got.byte_position,
                                got.last_byte, got.overflow));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;     // value[63:0]
  logic [4:0]  in_tuser = '0;     // command[4:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // data_byte[7:0], byte_position[23:8]
  logic        out_tlast;
  logic        out_tuser;         // overflow[0]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  axdr_byte_scoreboard byte_sb;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int settings_written = 0;
  bit hold_request = 1'b0;

  axdr_typed_value_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      byte_sb.check_byte(axdr_beat_t'({out_tdata[7:0], out_tdata[23:8], out_tlast, out_tuser}));
  end

  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] lengths[8] = '{64'h7F, 64'h80, 64'hFF, 64'h100, 64'hFFFF, 64'h1_0000,
                                64'hFFFF_FFFF, 64'hFFFF_FFFF_0000_0080};
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return 64'($urandom_range(0, 300));
      4: return lengths[$urandom_range(0, 7)];
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat (gap_length()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [4:0] cmd, logic [63:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
    byte_sb.note_input(cmd, value);
    gap = ($urandom_range(0, 99) < idle_pct) ? gap_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (byte_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] cap);
    logic [31:0] readback;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * REG_CAPACITY);
    cfg_pwdata <= {16'h0, cap};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    byte_sb.set_capacity(cap);
    settings_written++;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (readback[15:0] !== cap)
      byte_sb.flag_mismatch($sformatf("capacity readback expected %0d, got %0d",
                                      cap, readback[15:0]));
  endtask

  // Headers are mostly followed by raw beats of the announced length.
  task automatic run_random(int count);
    int          sent;
    int          len;
    cmd_t        hdr;
    logic [63:0] value;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 19))
        0: begin
          send_item(CMD_START, rand_value());
          sent++;
        end
        1: send_item(5'($urandom_range(20, 31)), rand_value());
        2, 3, 4, 5, 6: begin
          hdr = cmd_t'($urandom_range(CMD_OCTET_HDR, CMD_ARRAY_HDR));
          len = $urandom_range(0, 6);
          value = {($urandom_range(0, 3) == 0) ? $urandom : 32'h0, 32'(len)};
          send_item(hdr, value);
          sent++;
          repeat (len) begin
            send_item(CMD_RAW, rand_value());
            sent++;
          end
        end
        default: begin
          send_item(5'($urandom_range(CMD_NULL, CMD_LENGTH)), rand_value());
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    byte_sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_capacity(CAPACITY_RESET);

    send_item(CMD_NULL, '1);
    send_item(CMD_BOOL, '0);
    send_item(CMD_BOOL, 64'h8000_0000_0000_0000);
    send_item(CMD_U8, '1);
    send_item(CMD_I8, 64'h80);
    send_item(CMD_U16, 64'hFFFF);
    send_item(CMD_I16, 64'h8000);
    send_item(CMD_U32, '1);
    send_item(CMD_I32, 64'h8000_0000);
    send_item(CMD_U64, '1);
    send_item(CMD_I64, 64'h8000_0000_0000_0000);
    send_item(CMD_FLOAT, 64'h3F80_0000);
    send_item(CMD_ENUM, 64'hFF);
    send_item(CMD_OCTET_HDR, 64'h7F);
    send_item(CMD_VIS_HDR, 64'h80);
    send_item(CMD_BITSTR_HDR, 64'hFF);
    send_item(CMD_STRUCT_HDR, 64'h100);
    send_item(CMD_ARRAY_HDR, 64'hFFFF);
    send_item(CMD_LENGTH, 64'h1_0000);
    send_item(CMD_LENGTH, '1);
    send_item(CMD_OCTET_HDR, 64'hFFFF_FFFF_0000_0000);
    send_item(CMD_RAW, 64'h1234_5678_9ABC_DEA5);
    send_item(CMD_START, '1);
    send_item(5'd20, '1);
    send_item(5'd31, '1);
    wait_idle();

    idle_pct = 30;
    stall_pct = 30;
    write_capacity(16'd0);
    send_item(CMD_START, '0);
    run_random(6);
    wait_idle();

    write_capacity(CAPACITY_RESET);
    send_item(CMD_START, '0);
    repeat (8) send_item(CMD_U32, rand_value());
    wait_idle();

    // Capacity now sits below the offset, so everything overflows until a start.
    write_capacity(16'd5);
    send_item(CMD_I16, rand_value());
    send_item(CMD_NULL, rand_value());
    send_item(CMD_RAW, rand_value());
    send_item(CMD_BITSTR_HDR, rand_value());
    send_item(CMD_START, '0);
    run_random(10);
    wait_idle();

    idle_pct = 20;
    stall_pct = 40;
    write_capacity(16'd24);
    send_item(CMD_START, '0);
    run_random(15);
    wait_idle();

    write_capacity(16'hFFFF);
    send_item(CMD_START, '0);
    run_random(20);
    wait_idle();

    idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b1;
    repeat (12) send_item($urandom_range(0, 1) ? CMD_U64 : CMD_I64, rand_value());
    wait_idle();

    idle_pct = 25;
    stall_pct = 25;
    write_capacity(CAPACITY_RESET);
    run_random(20);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("Run covered %0d input beats and %0d output beats (%0d overflow beats)",
             byte_sb.items_seen, byte_sb.beats_checked, byte_sb.overflow_beats);
    $display("over %0d capacity settings, including zero, full range and below the offset.",
             settings_written);
    if (byte_sb.mismatches == 0 && byte_sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/axdr_tve_pkg.sv
rtl/axdr_typed_value_encoder.sv
dv/testbench.sv
